// ----- rtl/core/readout_trailer_decoder_core_defines.svh -----
// Assertion macros for the readout trailer decoder core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef READOUT_TRAILER_DECODER_CORE_DEFINES_SVH
`define READOUT_TRAILER_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rtd_pkg.sv -----
// Types and constants shared by the readout trailer decoder core.
// No dependencies; used by rtd_in_stage, rtd_decode and the top level.
`default_nettype none

package rtd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = 7;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PARAM = 3'b010,
		PH_SIZE  = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_MARKER   = 3'd1,
		ST_UNKNOWN_CODE = 3'd2,
		ST_COMPLETE     = 3'd3,
		ST_NO_TRAILER   = 3'd4,
		ST_SIZE_INVALID = 3'd5
	} status_t;

	localparam logic [1:0] MARK_TRAILER = 2'd3;
	localparam logic [1:0] MARK_PARAM   = 2'd2;
	localparam logic [CNT_W-1:0] MIN_COUNT = 7'd2;

	localparam logic [3:0] CODE_BOARD_ERR = 4'd1;
	localparam logic [3:0] CODE_ERR_TWO   = 4'd2;
	localparam logic [3:0] CODE_ERR_THREE = 4'd3;
	localparam logic [3:0] CODE_BOARDS_A  = 4'd4;
	localparam logic [3:0] CODE_BOARDS_B  = 4'd5;
	localparam logic [3:0] CODE_CFG_ONE   = 4'd6;
	localparam logic [3:0] CODE_CFG_TWO   = 4'd7;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              start_req;
	} in_item_t;

	typedef struct packed {
		logic [8:0]       unit_id;
		logic [7:0]       firmware;
		logic [CNT_W-1:0] count;
		logic [25:0]      payload;
		logic [19:0]      error_a;
		logic [19:0]      error_b;
		logic [8:0]       error_two;
		logic [24:0]      error_three;
		logic [15:0]      boards_a;
		logic [15:0]      boards_b;
		logic [19:0]      cfg_one;
		logic [24:0]      cfg_two;
	} record_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] words_left;
		record_t          rec;
	} dec_state_t;

	localparam record_t REC_RESET = '{
		unit_id:     9'h1FF,
		firmware:    8'd0,
		count:       7'd0,
		payload:     26'd0,
		error_a:     20'd0,
		error_b:     20'd0,
		error_two:   9'd0,
		error_three: 25'd0,
		boards_a:    16'd0,
		boards_b:    16'd0,
		cfg_one:     20'd0,
		cfg_two:     25'd0
	};

	// Output tdata width: all result fields but status, rounded up to whole bytes.
	localparam int unsigned OUT_BITS   = 201;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- rtl/core/rtd_in_stage.sv -----
// Input register of the readout trailer decoder: holds one accepted item.
// Depends on rtd_pkg and the assertion macro header.
`default_nettype none
`include "readout_trailer_decoder_core_defines.svh"

module rtd_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire rtd_pkg::in_item_t in_item,
	input  wire logic             advance,
	output logic                  valid_s1,
	output rtd_pkg::in_item_t     item_s1
);

	// Take a new item when the register is empty or the held one moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	`RTD_ASSERT_NEXT(a_hold_item, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1), "held item changed while stalled")
	`RTD_ASSERT_IMPL(a_advance_valid, clk, arst_n, advance, valid_s1, "advance without a held item")
	`RTD_ASSERT_NEXT(a_load, clk, arst_n, in_valid && in_ready, valid_s1, "accepted item not held")

endmodule

`default_nettype wire

// ----- rtl/core/rtd_decode.sv -----
// Next-state and status logic of the readout trailer decoder for one word.
// Depends on rtd_pkg; purely combinational.
`default_nettype none

module rtd_decode (
	input  wire rtd_pkg::in_item_t   item,
	input  wire rtd_pkg::dec_state_t cur,
	output rtd_pkg::dec_state_t      nxt,
	output rtd_pkg::status_t         status
);

	logic [1:0] marker;
	logic [3:0] code;

	assign marker = item.word[31:30];
	assign code   = item.word[29:26];

	always_comb begin
		nxt    = cur;
		status = rtd_pkg::ST_NO_TRAILER;
		if (item.start_req) begin
			// Drop any decode in progress and start from a clean record.
			nxt.rec        = rtd_pkg::REC_RESET;
			nxt.phase      = rtd_pkg::PH_IDLE;
			nxt.words_left = '0;
			if (marker == rtd_pkg::MARK_TRAILER) begin
				nxt.rec.firmware = item.word[23:16];
				nxt.rec.unit_id  = item.word[15:7];
				if (item.word[6:0] < rtd_pkg::MIN_COUNT) begin
					status = rtd_pkg::ST_SIZE_INVALID;
				end else begin
					nxt.rec.count  = item.word[6:0];
					nxt.words_left = item.word[6:0];
					nxt.phase      = rtd_pkg::PH_PARAM;
					status         = rtd_pkg::ST_OK;
				end
			end
		end else begin
			case (cur.phase)
				rtd_pkg::PH_PARAM: begin
					nxt.words_left = cur.words_left - 7'd1;
					if (cur.words_left == 7'd1) begin
						nxt.phase = rtd_pkg::PH_SIZE;
					end
					if (marker != rtd_pkg::MARK_PARAM) begin
						status = rtd_pkg::ST_BAD_MARKER;
					end else begin
						status = rtd_pkg::ST_OK;
						case (code)
							rtd_pkg::CODE_BOARD_ERR: begin
								nxt.rec.error_a = {item.word[25:13], 7'd0};
								nxt.rec.error_b = {item.word[12:0], 7'd0};
							end
							rtd_pkg::CODE_ERR_TWO:   nxt.rec.error_two   = item.word[8:0];
							rtd_pkg::CODE_ERR_THREE: nxt.rec.error_three = item.word[24:0];
							rtd_pkg::CODE_BOARDS_A:  nxt.rec.boards_a    = item.word[15:0];
							rtd_pkg::CODE_BOARDS_B:  nxt.rec.boards_b    = item.word[15:0];
							rtd_pkg::CODE_CFG_ONE:   nxt.rec.cfg_one     = item.word[19:0];
							rtd_pkg::CODE_CFG_TWO:   nxt.rec.cfg_two     = item.word[24:0];
							default:                 status = rtd_pkg::ST_UNKNOWN_CODE;
						endcase
					end
				end
				rtd_pkg::PH_SIZE: begin
					nxt.rec.payload = item.word[25:0];
					nxt.phase       = rtd_pkg::PH_IDLE;
					status          = rtd_pkg::ST_COMPLETE;
				end
				default: begin
					// Stray word with no decode open: keep the record and report no trailer.
					nxt.phase = rtd_pkg::PH_IDLE;
					status    = rtd_pkg::ST_NO_TRAILER;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/readout_trailer_decoder_core.sv -----
// Readout trailer decoder core: input register, decode logic, record/result register.
// A word passes the input register, then the record register, which presents its result.
// One word a cycle while results are taken; set by the single decode step between them.
// Reset (arst_n low, asynchronous): no decode open, unit id all ones, all other fields zero.
// Depends on rtd_pkg, rtd_in_stage, rtd_decode and the assertion macro header.
`default_nettype none
`include "readout_trailer_decoder_core_defines.svh"

module readout_trailer_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] word
	input  wire logic [0:0]  s_axis_tuser,  // [0] start_req
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [8:0] unit_id, [16:9] firmware_version, [23:17] trailer_count,
	// [49:24] payload_size, [69:50] board_error_a, [89:70] board_error_b,
	// [98:90] error_two, [123:99] error_three, [155:124] active_boards,
	// [175:156] readout_cfg_one, [200:176] readout_cfg_two, [207:201] zero
	output logic [rtd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [2:0]       m_axis_tuser   // [2:0] status
);

	rtd_pkg::in_item_t   in_item;
	rtd_pkg::in_item_t   item_s1;
	logic                valid_s1;
	logic                advance;
	rtd_pkg::dec_state_t state_q;
	rtd_pkg::dec_state_t state_nxt;
	rtd_pkg::status_t    status_nxt;
	rtd_pkg::status_t    status_q;
	logic                out_valid_q;

	assign in_item.word      = s_axis_tdata;
	assign in_item.start_req = s_axis_tuser[0];

	// The record register doubles as the result register: advance when it is free or taken.
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	rtd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rtd_decode u_decode (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.status (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= rtd_pkg::PH_IDLE;
			state_q.words_left <= '0;
			state_q.rec        <= rtd_pkg::REC_RESET;
			out_valid_q        <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {
		{(rtd_pkg::OUT_DATA_W - rtd_pkg::OUT_BITS){1'b0}},
		state_q.rec.cfg_two,
		state_q.rec.cfg_one,
		state_q.rec.boards_b,
		state_q.rec.boards_a,
		state_q.rec.error_three,
		state_q.rec.error_two,
		state_q.rec.error_b,
		state_q.rec.error_a,
		state_q.rec.payload,
		state_q.rec.count,
		state_q.rec.firmware,
		state_q.rec.unit_id
	};

	`RTD_ASSERT_NEXT(a_state_hold, clk, arst_n, !advance, $stable(state_q),
		"record changed without a word")
	`RTD_ASSERT_IMPL(a_param_left, clk, arst_n, state_q.phase == rtd_pkg::PH_PARAM,
		state_q.words_left != 7'd0, "parameter phase with no words left")
	`RTD_ASSERT_IMPL(a_count_min, clk, arst_n, state_q.rec.count != 7'd0,
		state_q.rec.count >= rtd_pkg::MIN_COUNT, "stored trailer count below two")
	`RTD_ASSERT_NEXT(a_no_marker, clk, arst_n,
		advance && item_s1.start_req && (item_s1.word[31:30] != rtd_pkg::MARK_TRAILER),
		(status_q == rtd_pkg::ST_NO_TRAILER) && (state_q.rec == rtd_pkg::REC_RESET),
		"missing marker did not clear record")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for readout_trailer_decoder_core: directed trailers, then random records.
// Feeds words over the input stream, predicts every decoded record and checks the output stream.
// Depends on rtd_pkg and the core RTL only.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtd_pkg::*;

	localparam int unsigned HALF_PERIOD = 2;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned ITEM_TARGET = 850;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 12;

	// Parameter codes the block does not know
	localparam logic [3:0] CODE_NONE     = 4'd0;
	localparam logic [3:0] CODE_SPARE_LO = 4'd8;
	localparam logic [3:0] CODE_SPARE_HI = 4'd15;

	typedef enum logic [1:0] {
		DEC_IDLE,
		DEC_PARAMS,
		DEC_SIZE
	} dec_phase_e;

	typedef struct {
		logic [31:0] word;
		logic        start;
		bit          drain;
	} feed_item_t;

	typedef struct packed {
		status_t status;
		record_t rec;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0]            m_axis_tuser;

	feed_item_t  feed_q[$];
	outcome_t    pending_records[$];

	dec_phase_e  dec_phase = DEC_IDLE;
	logic [6:0]  params_left = '0;
	record_t     dec_rec = REC_RESET;

	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned words_fed = 0;
	int unsigned status_seen[6];
	int unsigned cycle_count = 0;
	bit          took_item = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned ready_mode = 0;
	int unsigned ready_left = 0;
	int unsigned ready_tick = 0;
	outcome_t    want;

	readout_trailer_decoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Decode one accepted word and queue the record the block must show for it.
	function automatic void decode_trailer_word(input logic [31:0] w, input logic start);
		status_t st;
		logic [25:0] data;
		outcome_t res;
		data = w[25:0];
		if (start) begin
			dec_rec = REC_RESET;
			dec_phase = DEC_IDLE;
			params_left = '0;
			if (w[31:30] != MARK_TRAILER) begin
				st = ST_NO_TRAILER;
			end else begin
				dec_rec.firmware = w[23:16];
				dec_rec.unit_id = w[15:7];
				if (w[6:0] < MIN_COUNT) begin
					st = ST_SIZE_INVALID;
				end else begin
					dec_rec.count = w[6:0];
					params_left = w[6:0];
					dec_phase = DEC_PARAMS;
					st = ST_OK;
				end
			end
		end else if (dec_phase == DEC_PARAMS) begin
			if (w[31:30] != MARK_PARAM) begin
				st = ST_BAD_MARKER;
			end else begin
				st = ST_OK;
				case (w[29:26])
					CODE_BOARD_ERR: begin
						dec_rec.error_a = {data[25:13], 7'd0};
						dec_rec.error_b = {data[12:0], 7'd0};
					end
					CODE_ERR_TWO:   dec_rec.error_two = data[8:0];
					CODE_ERR_THREE: dec_rec.error_three = data[24:0];
					CODE_BOARDS_A:  dec_rec.boards_a = data[15:0];
					CODE_BOARDS_B:  dec_rec.boards_b = data[15:0];
					CODE_CFG_ONE:   dec_rec.cfg_one = data[19:0];
					CODE_CFG_TWO:   dec_rec.cfg_two = data[24:0];
					default:        st = ST_UNKNOWN_CODE;
				endcase
			end
			params_left = params_left - 7'd1;
			if (params_left == '0)
				dec_phase = DEC_SIZE;
		end else if (dec_phase == DEC_SIZE) begin
			dec_rec.payload = data;
			dec_phase = DEC_IDLE;
			st = ST_COMPLETE;
		end else begin
			st = ST_NO_TRAILER;
		end
		res.status = st;
		res.rec = dec_rec;
		pending_records.push_back(res);
		status_seen[int'(st)]++;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	task automatic push_word(input logic [31:0] w, input logic start, input bit drain);
		feed_item_t it;
		it.word = w;
		it.start = start;
		it.drain = drain;
		feed_q.push_back(it);
	endtask

	function automatic logic [31:0] trailer_word(input logic [6:0] cnt);
		return {MARK_TRAILER, 6'($urandom), 8'($urandom), 9'($urandom), cnt};
	endfunction

	function automatic logic [1:0] bad_marker(input logic [1:0] good);
		logic [1:0] mark;
		do
			mark = 2'($urandom);
		while (mark == good);
		return mark;
	endfunction

	function automatic logic [31:0] random_param();
		int unsigned pick;
		logic [1:0] mark;
		logic [3:0] code;
		pick = $urandom_range(0, 99);
		mark = MARK_PARAM;
		if (pick < 80) begin
			code = 4'($urandom_range(CODE_BOARD_ERR, CODE_CFG_TWO));
		end else if (pick < 90) begin
			code = ($urandom_range(0, 1) == 0) ? CODE_NONE :
				4'($urandom_range(CODE_SPARE_LO, CODE_SPARE_HI));
		end else begin
			code = 4'($urandom);
			mark = bad_marker(MARK_PARAM);
		end
		return {mark, code, 26'($urandom)};
	endfunction

	// Queue one trailer; now and then cut it short so the next start word aborts it.
	task automatic push_random_record(input logic [6:0] cnt, input bit drain,
			inout int unsigned n);
		int unsigned cut;
		int unsigned i;
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, cnt) : cnt + 1;
		push_word(trailer_word(cnt), 1'b1, drain);
		n++;
		for (i = 0; i < cnt && i < cut; i++) begin
			push_word(random_param(), 1'b0, 1'b0);
			n++;
		end
		if (cut > cnt) begin
			push_word($urandom, 1'b0, 1'b0);
			n++;
		end
	endtask

	// Input side: accept at the rising edge, predict from what was on the bus.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			decode_trailer_word(s_axis_tdata, s_axis_tuser[0]);
			void'(feed_q.pop_front());
			words_fed++;
			took_item = 1'b1;
		end else begin
			took_item = 1'b0;
		end
	end

	// Input side: present the next item at the falling edge, in bursts with gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || took_item) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (feed_q.size() == 0 ||
					(feed_q[0].drain && pending_records.size() != 0)) begin
				// hold off until every outstanding record has come back
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= feed_q[0].word;
				s_axis_tuser <= feed_q[0].start;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
						$urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
		end
	end

	// Output side: stall on a pattern that switches between free flow, coin flips and
	// periodic back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_left = $urandom_range(8, 60);
			end
			ready_left--;
			ready_tick++;
			case (ready_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= 1'($urandom_range(0, 1));
				2:       m_axis_tready <= (ready_tick % 4) != 0;
				default: m_axis_tready <= (ready_tick % 7) < 2;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_records.size() == 0) begin
				report_mismatch("result with no record pending", m_axis_tuser, '0);
			end else begin
				want = pending_records.pop_front();
				results_checked++;
				check_field("status", m_axis_tuser, want.status);
				check_field("unit_id", m_axis_tdata[8:0], want.rec.unit_id);
				check_field("firmware_version", m_axis_tdata[16:9], want.rec.firmware);
				check_field("trailer_count", m_axis_tdata[23:17], want.rec.count);
				check_field("payload_size", m_axis_tdata[49:24], want.rec.payload);
				check_field("board_error_a", m_axis_tdata[69:50], want.rec.error_a);
				check_field("board_error_b", m_axis_tdata[89:70], want.rec.error_b);
				check_field("error_two", m_axis_tdata[98:90], want.rec.error_two);
				check_field("error_three", m_axis_tdata[123:99], want.rec.error_three);
				check_field("active_boards", m_axis_tdata[155:124],
					{want.rec.boards_b, want.rec.boards_a});
				check_field("readout_cfg_one", m_axis_tdata[175:156], want.rec.cfg_one);
				check_field("readout_cfg_two", m_axis_tdata[200:176], want.rec.cfg_two);
				check_field("padding", m_axis_tdata[207:201], '0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycle_count,
				pending_records.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned pick;
		int unsigned k;
		n = 0;

		// Directed: idle word, broken start words, every code with all data bits set, abort.
		push_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		push_word({MARK_PARAM, 30'h3FFF_FFFF}, 1'b1, 1'b0);
		push_word({MARK_TRAILER, 6'h3F, 8'hFF, 9'h1FF, 7'd0}, 1'b1, 1'b0);
		push_word({MARK_TRAILER, 6'h00, 8'h00, 9'h000, 7'd1}, 1'b1, 1'b0);
		push_word({MARK_TRAILER, 6'h15, 8'hA5, 9'h0F0, 7'd10}, 1'b1, 1'b0);
		push_word({MARK_PARAM, CODE_BOARD_ERR, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_ERR_TWO, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_ERR_THREE, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_BOARDS_A, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_BOARDS_B, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_CFG_ONE, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_CFG_TWO, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_NONE, 26'h3FF_FFFF}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_SPARE_HI, 26'h000_0000}, 1'b0, 1'b0);
		push_word({MARK_TRAILER, 30'h0}, 1'b0, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		push_word(32'h0000_0000, 1'b0, 1'b1);
		push_word({MARK_TRAILER, 6'h00, 8'h5A, 9'h1FF, 7'd2}, 1'b1, 1'b0);
		push_word({MARK_PARAM, CODE_CFG_TWO, 26'h155_5555}, 1'b0, 1'b0);
		push_word({MARK_TRAILER, 6'h2A, 8'hFF, 9'h000, 7'd2}, 1'b1, 1'b0);
		push_word({MARK_PARAM, CODE_BOARD_ERR, 26'h2AA_AAAA}, 1'b0, 1'b0);
		push_word({MARK_PARAM, CODE_BOARDS_A, 26'h000_0000}, 1'b0, 1'b0);
		push_word(32'h0000_0000, 1'b0, 1'b0);

		// Random: one record at the largest count, then mostly well-formed trailers.
		push_random_record(7'd127, 1'b1, n);
		while (n < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				k = $urandom_range(0, 59);
				push_random_record((k == 0) ? 7'($urandom_range(100, 127)) :
					(k < 8) ? 7'($urandom_range(11, 99)) : 7'($urandom_range(2, 10)),
					$urandom_range(0, 39) == 0, n);
			end else if (pick < 88) begin
				// stray words between records; no-trailer status each unless a cut-short trailer is open
				for (k = $urandom_range(1, 3); k != 0; k--)
					push_word($urandom, 1'b0, 1'b0);
			end else if (pick < 94) begin
				push_word({bad_marker(MARK_TRAILER), 30'($urandom)}, 1'b1, 1'b0);
				n++;
			end else begin
				push_word(trailer_word(7'($urandom_range(0, 1))), 1'b1, 1'b0);
				n++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || pending_records.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("fed %0d words, checked %0d results in %0d cycles", words_fed,
			results_checked, cycle_count);
		$display("records complete %0d, bad markers %0d, unknown codes %0d, no trailer %0d,"
			, status_seen[int'(ST_COMPLETE)], status_seen[int'(ST_BAD_MARKER)],
			status_seen[int'(ST_UNKNOWN_CODE)], status_seen[int'(ST_NO_TRAILER)],
			" bad counts %0d", status_seen[int'(ST_SIZE_INVALID)]);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rtd_pkg.sv
rtl/core/rtd_in_stage.sv
rtl/core/rtd_decode.sv
rtl/core/readout_trailer_decoder_core.sv
verif/tb.sv
